@@ rtl/core/mge_pkg.sv @@
package mge_pkg;

    typedef logic signed [63:0] fx_t;

    localparam fx_t FX_ONE  = 64'sh0000_0001_0000_0000;
    localparam fx_t FX_HALF = 64'sh0000_0000_8000_0000;
    localparam fx_t FX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fx_t FX_MIN  = 64'sh8000_0000_0000_0000;

    localparam int QBITS = 96;

    typedef enum logic [1:0] {
        REG_RHO0  = 2'd0,
        REG_GAMMA = 2'd1,
        REG_C0    = 2'd2,
        REG_SLOPE = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_RHO = 2'd1,
        ST_BAD_DEN = 2'd2,
        ST_SAT     = 2'd3
    } status_t;

    typedef struct packed {
        fx_t density;
        fx_t internal_energy;
    } req_t;

    typedef struct packed {
        fx_t     pressure;
        fx_t     bulk_modulus;
        status_t status;
    } rsp_t;

    typedef struct packed {
        fx_t  rho;
        fx_t  e;
        fx_t  r;
        fx_t  mu;
        fx_t  den;
        fx_t  us;
        fx_t  u2;
        fx_t  mm;
        fx_t  rho0u2;
        fx_t  ph;
        fx_t  eh;
        fx_t  g;
        fx_t  p;
        fx_t  dmu;
        fx_t  dus;
        fx_t  usdus;
        fx_t  a;
        fx_t  dph;
        fx_t  deh;
        fx_t  t1;
        fx_t  t2;
        logic ov;
        logic bad_rho;
        logic bad_den;
    } ctx_t;

    typedef struct packed {
        logic ov;
        fx_t  v;
    } fx_res_t;

    function automatic logic [63:0] fx_mag(input fx_t x);
        logic [63:0] m;
        begin
            m = x[63] ? (64'd0 - 64'(x)) : 64'(x);
            return m;
        end
    endfunction

    function automatic fx_res_t fx_pack(input logic neg, input logic [63:0] m,
                                        input logic big);
        fx_res_t res;
        begin
            res.ov = 1'b0;
            if (neg)
            begin
                if (big || (m > 64'h8000_0000_0000_0000))
                begin
                    res.ov = 1'b1;
                    res.v  = FX_MIN;
                end
                else
                begin
                    res.v = fx_t'(64'd0 - m);
                end
            end
            else
            begin
                if (big || m[63])
                begin
                    res.ov = 1'b1;
                    res.v  = FX_MAX;
                end
                else
                begin
                    res.v = fx_t'(m);
                end
            end
            return res;
        end
    endfunction

    function automatic fx_res_t fx_addsub(input fx_t a, input fx_t b, input logic sub);
        logic [64:0] s;
        fx_res_t     res;
        begin
            if (sub)
            begin
                s = {a[63], a} - {b[63], b};
            end
            else
            begin
                s = {a[63], a} + {b[63], b};
            end
            res.ov = (s[64] != s[63]);
            if (res.ov)
            begin
                res.v = s[64] ? FX_MIN : FX_MAX;
            end
            else
            begin
                res.v = fx_t'(s[63:0]);
            end
            return res;
        end
    endfunction

endpackage

@@ rtl/core/mie_gruneisen_eos_core.sv @@
// Channel   Direction  Valid      Stall      Payload
// request   in         req_valid  req_stall  req (density, internal_energy)
// response  out        rsp_valid  rsp_stall  rsp (pressure, bulk_modulus, status)
// config    in         cfg_we     none       cfg_index, cfg_data
//
// One transfer is taken per cycle while the response is not stalled.
// The datapath chains five 98-stage radix-2 dividers with the 3-stage
// multipliers and 1-stage adders between them.
// Reset clears all valid bits and loads the register defaults.
// A stalled response freezes the whole pipeline and raises req_stall.
module mie_gruneisen_eos_core
    import mge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_index,
    input  logic [62:0] cfg_data
);

    localparam int NSTEP = 35;

    logic [62:0] rho0_reg;
    logic [62:0] gamma_reg;
    logic [62:0] c0_reg;
    logic [62:0] slope_reg;

    fx_t  rho0_fx;
    fx_t  gamma_fx;
    fx_t  c0_fx;
    fx_t  slope_fx;

    logic en;
    ctx_t c  [0:NSTEP];
    logic v  [0:NSTEP];
    ctx_t co [1:NSTEP];
    fx_t  y  [1:NSTEP];
    logic ov [1:NSTEP];

    logic rsp_vld_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    assign rho0_fx  = {1'b0, rho0_reg};
    assign gamma_fx = {1'b0, gamma_reg};
    assign c0_fx    = {1'b0, c0_reg};
    assign slope_fx = {1'b0, slope_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rho0_reg  <= 63'h0000_0001_0000_0000;
            gamma_reg <= 63'h0000_0002_0000_0000;
            c0_reg    <= 63'h0000_0001_0000_0000;
            slope_reg <= 63'h0000_0001_8000_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RHO0:  rho0_reg  <= cfg_data;
                REG_GAMMA: gamma_reg <= cfg_data;
                REG_C0:    c0_reg    <= cfg_data;
                REG_SLOPE: slope_reg <= cfg_data;
            endcase
        end
    end

    assign en        = !(rsp_vld_reg && rsp_stall);
    assign req_stall = !en;

    always_comb
    begin
        c[0]         = '0;
        c[0].rho     = req.density;
        c[0].e       = req.internal_energy;
        c[0].bad_rho = (req.density <= 64'sd0);
        v[0]         = req_valid;
    end

    // r = rho0 / rho
    mge_div u_s01 (.clk, .rst_n, .en, .vld_in(v[0]), .ctx_in(c[0]), .a(rho0_fx),
        .b(c[0].rho), .vld_out(v[1]), .ctx_out(co[1]), .y(y[1]), .ov(ov[1]));
    always_comb
    begin
        c[1] = co[1]; c[1].r = y[1]; c[1].ov = co[1].ov | ov[1];
    end

    mge_add u_s02 (.clk, .rst_n, .en, .vld_in(v[1]), .ctx_in(c[1]), .a(FX_ONE),
        .b(c[1].r), .sub(1'b1), .vld_out(v[2]), .ctx_out(co[2]), .y(y[2]), .ov(ov[2]));
    always_comb
    begin
        c[2] = co[2]; c[2].mu = y[2]; c[2].ov = co[2].ov | ov[2];
    end

    mge_mul u_s03 (.clk, .rst_n, .en, .vld_in(v[2]), .ctx_in(c[2]), .a(slope_fx),
        .b((c[2].mu > 64'sd0) ? c[2].mu : 64'sd0),
        .vld_out(v[3]), .ctx_out(co[3]), .y(y[3]), .ov(ov[3]));
    always_comb
    begin
        c[3] = co[3]; c[3].t1 = y[3]; c[3].ov = co[3].ov | ov[3];
    end

    mge_add u_s04 (.clk, .rst_n, .en, .vld_in(v[3]), .ctx_in(c[3]), .a(FX_ONE),
        .b(c[3].t1), .sub(1'b1), .vld_out(v[4]), .ctx_out(co[4]), .y(y[4]), .ov(ov[4]));
    always_comb
    begin
        c[4] = co[4]; c[4].den = y[4]; c[4].ov = co[4].ov | ov[4];
        c[4].bad_den = (y[4] <= 64'sd0);
    end

    mge_div u_s05 (.clk, .rst_n, .en, .vld_in(v[4]), .ctx_in(c[4]), .a(c0_fx),
        .b(c[4].den), .vld_out(v[5]), .ctx_out(co[5]), .y(y[5]), .ov(ov[5]));
    always_comb
    begin
        c[5] = co[5]; c[5].us = y[5]; c[5].ov = co[5].ov | ov[5];
    end

    mge_mul u_s06 (.clk, .rst_n, .en, .vld_in(v[5]), .ctx_in(c[5]), .a(c[5].us),
        .b(c[5].us), .vld_out(v[6]), .ctx_out(co[6]), .y(y[6]), .ov(ov[6]));
    always_comb
    begin
        c[6] = co[6]; c[6].u2 = y[6]; c[6].ov = co[6].ov | ov[6];
    end

    mge_mul u_s07 (.clk, .rst_n, .en, .vld_in(v[6]), .ctx_in(c[6]), .a(c[6].mu),
        .b(c[6].mu), .vld_out(v[7]), .ctx_out(co[7]), .y(y[7]), .ov(ov[7]));
    always_comb
    begin
        c[7] = co[7]; c[7].mm = y[7]; c[7].ov = co[7].ov | ov[7];
    end

    mge_mul u_s08 (.clk, .rst_n, .en, .vld_in(v[7]), .ctx_in(c[7]), .a(rho0_fx),
        .b(c[7].u2), .vld_out(v[8]), .ctx_out(co[8]), .y(y[8]), .ov(ov[8]));
    always_comb
    begin
        c[8] = co[8]; c[8].rho0u2 = y[8]; c[8].ov = co[8].ov | ov[8];
    end

    mge_mul u_s09 (.clk, .rst_n, .en, .vld_in(v[8]), .ctx_in(c[8]), .a(c[8].rho0u2),
        .b(c[8].mu), .vld_out(v[9]), .ctx_out(co[9]), .y(y[9]), .ov(ov[9]));
    always_comb
    begin
        c[9] = co[9]; c[9].ph = y[9]; c[9].ov = co[9].ov | ov[9];
    end

    mge_mul u_s10 (.clk, .rst_n, .en, .vld_in(v[9]), .ctx_in(c[9]), .a(c[9].u2),
        .b(c[9].mm), .vld_out(v[10]), .ctx_out(co[10]), .y(y[10]), .ov(ov[10]));
    always_comb
    begin
        c[10] = co[10]; c[10].t1 = y[10]; c[10].ov = co[10].ov | ov[10];
    end

    mge_mul u_s11 (.clk, .rst_n, .en, .vld_in(v[10]), .ctx_in(c[10]), .a(FX_HALF),
        .b(c[10].t1), .vld_out(v[11]), .ctx_out(co[11]), .y(y[11]), .ov(ov[11]));
    always_comb
    begin
        c[11] = co[11]; c[11].eh = y[11]; c[11].ov = co[11].ov | ov[11];
    end

    mge_mul u_s12 (.clk, .rst_n, .en, .vld_in(v[11]), .ctx_in(c[11]), .a(gamma_fx),
        .b(rho0_fx), .vld_out(v[12]), .ctx_out(co[12]), .y(y[12]), .ov(ov[12]));
    always_comb
    begin
        c[12] = co[12]; c[12].g = y[12]; c[12].ov = co[12].ov | ov[12];
    end

    mge_add u_s13 (.clk, .rst_n, .en, .vld_in(v[12]), .ctx_in(c[12]), .a(c[12].e),
        .b(c[12].eh), .sub(1'b1), .vld_out(v[13]), .ctx_out(co[13]), .y(y[13]),
        .ov(ov[13]));
    always_comb
    begin
        c[13] = co[13]; c[13].t1 = y[13]; c[13].ov = co[13].ov | ov[13];
    end

    mge_mul u_s14 (.clk, .rst_n, .en, .vld_in(v[13]), .ctx_in(c[13]), .a(c[13].g),
        .b(c[13].t1), .vld_out(v[14]), .ctx_out(co[14]), .y(y[14]), .ov(ov[14]));
    always_comb
    begin
        c[14] = co[14]; c[14].t1 = y[14]; c[14].ov = co[14].ov | ov[14];
    end

    mge_add u_s15 (.clk, .rst_n, .en, .vld_in(v[14]), .ctx_in(c[14]), .a(c[14].ph),
        .b(c[14].t1), .sub(1'b0), .vld_out(v[15]), .ctx_out(co[15]), .y(y[15]),
        .ov(ov[15]));
    always_comb
    begin
        c[15] = co[15]; c[15].p = y[15]; c[15].ov = co[15].ov | ov[15];
    end

    mge_div u_s16 (.clk, .rst_n, .en, .vld_in(v[15]), .ctx_in(c[15]), .a(c[15].r),
        .b(c[15].rho), .vld_out(v[16]), .ctx_out(co[16]), .y(y[16]), .ov(ov[16]));
    always_comb
    begin
        c[16] = co[16]; c[16].dmu = y[16]; c[16].ov = co[16].ov | ov[16];
    end

    // The shock speed derivative only exists in compression.
    mge_mul u_s17 (.clk, .rst_n, .en, .vld_in(v[16]), .ctx_in(c[16]), .a(c[16].us),
        .b(slope_fx), .vld_out(v[17]), .ctx_out(co[17]), .y(y[17]), .ov(ov[17]));
    always_comb
    begin
        c[17] = co[17]; c[17].t1 = y[17];
        c[17].ov = co[17].ov | (ov[17] && (co[17].mu > 64'sd0));
    end

    mge_div u_s18 (.clk, .rst_n, .en, .vld_in(v[17]), .ctx_in(c[17]), .a(c[17].t1),
        .b(c[17].den), .vld_out(v[18]), .ctx_out(co[18]), .y(y[18]), .ov(ov[18]));
    always_comb
    begin
        c[18] = co[18]; c[18].t1 = y[18];
        c[18].ov = co[18].ov | (ov[18] && (co[18].mu > 64'sd0));
    end

    mge_mul u_s19 (.clk, .rst_n, .en, .vld_in(v[18]), .ctx_in(c[18]), .a(c[18].t1),
        .b(c[18].dmu), .vld_out(v[19]), .ctx_out(co[19]), .y(y[19]), .ov(ov[19]));
    always_comb
    begin
        c[19] = co[19];
        c[19].dus = (co[19].mu > 64'sd0) ? y[19] : 64'sd0;
        c[19].ov = co[19].ov | (ov[19] && (co[19].mu > 64'sd0));
    end

    mge_mul u_s20 (.clk, .rst_n, .en, .vld_in(v[19]), .ctx_in(c[19]), .a(c[19].us),
        .b(c[19].dus), .vld_out(v[20]), .ctx_out(co[20]), .y(y[20]), .ov(ov[20]));
    always_comb
    begin
        c[20] = co[20]; c[20].usdus = y[20]; c[20].ov = co[20].ov | ov[20];
    end

    mge_mul u_s21 (.clk, .rst_n, .en, .vld_in(v[20]), .ctx_in(c[20]), .a(rho0_fx),
        .b(c[20].usdus), .vld_out(v[21]), .ctx_out(co[21]), .y(y[21]), .ov(ov[21]));
    always_comb
    begin
        c[21] = co[21]; c[21].t1 = y[21]; c[21].ov = co[21].ov | ov[21];
    end

    mge_mul u_s22 (.clk, .rst_n, .en, .vld_in(v[21]), .ctx_in(c[21]), .a(c[21].t1),
        .b(c[21].mu), .vld_out(v[22]), .ctx_out(co[22]), .y(y[22]), .ov(ov[22]));
    always_comb
    begin
        c[22] = co[22]; c[22].a = y[22]; c[22].ov = co[22].ov | ov[22];
    end

    mge_mul u_s23 (.clk, .rst_n, .en, .vld_in(v[22]), .ctx_in(c[22]),
        .a(c[22].rho0u2), .b(c[22].dmu), .vld_out(v[23]), .ctx_out(co[23]), .y(y[23]),
        .ov(ov[23]));
    always_comb
    begin
        c[23] = co[23]; c[23].t1 = y[23]; c[23].ov = co[23].ov | ov[23];
    end

    mge_add u_s24 (.clk, .rst_n, .en, .vld_in(v[23]), .ctx_in(c[23]), .a(c[23].a),
        .b(c[23].a), .sub(1'b0), .vld_out(v[24]), .ctx_out(co[24]), .y(y[24]),
        .ov(ov[24]));
    always_comb
    begin
        c[24] = co[24]; c[24].t2 = y[24]; c[24].ov = co[24].ov | ov[24];
    end

    mge_add u_s25 (.clk, .rst_n, .en, .vld_in(v[24]), .ctx_in(c[24]), .a(c[24].t2),
        .b(c[24].t1), .sub(1'b0), .vld_out(v[25]), .ctx_out(co[25]), .y(y[25]),
        .ov(ov[25]));
    always_comb
    begin
        c[25] = co[25]; c[25].dph = y[25]; c[25].ov = co[25].ov | ov[25];
    end

    mge_mul u_s26 (.clk, .rst_n, .en, .vld_in(v[25]), .ctx_in(c[25]), .a(c[25].usdus),
        .b(c[25].mm), .vld_out(v[26]), .ctx_out(co[26]), .y(y[26]), .ov(ov[26]));
    always_comb
    begin
        c[26] = co[26]; c[26].t1 = y[26]; c[26].ov = co[26].ov | ov[26];
    end

    mge_mul u_s27 (.clk, .rst_n, .en, .vld_in(v[26]), .ctx_in(c[26]), .a(c[26].u2),
        .b(c[26].mu), .vld_out(v[27]), .ctx_out(co[27]), .y(y[27]), .ov(ov[27]));
    always_comb
    begin
        c[27] = co[27]; c[27].t2 = y[27]; c[27].ov = co[27].ov | ov[27];
    end

    mge_mul u_s28 (.clk, .rst_n, .en, .vld_in(v[27]), .ctx_in(c[27]), .a(c[27].t2),
        .b(c[27].dmu), .vld_out(v[28]), .ctx_out(co[28]), .y(y[28]), .ov(ov[28]));
    always_comb
    begin
        c[28] = co[28]; c[28].t2 = y[28]; c[28].ov = co[28].ov | ov[28];
    end

    mge_add u_s29 (.clk, .rst_n, .en, .vld_in(v[28]), .ctx_in(c[28]), .a(c[28].t1),
        .b(c[28].t2), .sub(1'b0), .vld_out(v[29]), .ctx_out(co[29]), .y(y[29]),
        .ov(ov[29]));
    always_comb
    begin
        c[29] = co[29]; c[29].deh = y[29]; c[29].ov = co[29].ov | ov[29];
    end

    mge_mul u_s30 (.clk, .rst_n, .en, .vld_in(v[29]), .ctx_in(c[29]), .a(c[29].g),
        .b(c[29].deh), .vld_out(v[30]), .ctx_out(co[30]), .y(y[30]), .ov(ov[30]));
    always_comb
    begin
        c[30] = co[30]; c[30].t1 = y[30]; c[30].ov = co[30].ov | ov[30];
    end

    mge_add u_s31 (.clk, .rst_n, .en, .vld_in(v[30]), .ctx_in(c[30]), .a(c[30].dph),
        .b(c[30].t1), .sub(1'b1), .vld_out(v[31]), .ctx_out(co[31]), .y(y[31]),
        .ov(ov[31]));
    always_comb
    begin
        c[31] = co[31]; c[31].t1 = y[31]; c[31].ov = co[31].ov | ov[31];
    end

    mge_mul u_s32 (.clk, .rst_n, .en, .vld_in(v[31]), .ctx_in(c[31]), .a(c[31].rho),
        .b(c[31].t1), .vld_out(v[32]), .ctx_out(co[32]), .y(y[32]), .ov(ov[32]));
    always_comb
    begin
        c[32] = co[32]; c[32].t1 = y[32]; c[32].ov = co[32].ov | ov[32];
    end

    mge_div u_s33 (.clk, .rst_n, .en, .vld_in(v[32]), .ctx_in(c[32]), .a(c[32].p),
        .b(c[32].rho), .vld_out(v[33]), .ctx_out(co[33]), .y(y[33]), .ov(ov[33]));
    always_comb
    begin
        c[33] = co[33]; c[33].t2 = y[33]; c[33].ov = co[33].ov | ov[33];
    end

    mge_mul u_s34 (.clk, .rst_n, .en, .vld_in(v[33]), .ctx_in(c[33]), .a(c[33].t2),
        .b(c[33].g), .vld_out(v[34]), .ctx_out(co[34]), .y(y[34]), .ov(ov[34]));
    always_comb
    begin
        c[34] = co[34]; c[34].t2 = y[34]; c[34].ov = co[34].ov | ov[34];
    end

    mge_add u_s35 (.clk, .rst_n, .en, .vld_in(v[34]), .ctx_in(c[34]), .a(c[34].t1),
        .b(c[34].t2), .sub(1'b0), .vld_out(v[35]), .ctx_out(co[35]), .y(y[35]),
        .ov(ov[35]));
    always_comb
    begin
        c[35] = co[35]; c[35].t1 = y[35]; c[35].ov = co[35].ov | ov[35];
    end

    always_comb
    begin
        rsp_next = '0;
        priority if (c[NSTEP].bad_rho)
        begin
            rsp_next.status = ST_BAD_RHO;
        end
        else if (c[NSTEP].bad_den)
        begin
            rsp_next.status = ST_BAD_DEN;
        end
        else
        begin
            rsp_next.pressure     = c[NSTEP].p;
            rsp_next.bulk_modulus = c[NSTEP].t1;
            rsp_next.status       = c[NSTEP].ov ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_vld_reg <= v[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/mge_add.sv @@
module mge_add
    import mge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic vld_in,
    input  ctx_t ctx_in,
    input  fx_t  a,
    input  fx_t  b,
    input  logic sub,
    output logic vld_out,
    output ctx_t ctx_out,
    output fx_t  y,
    output logic ov
);

    fx_res_t res_next;
    fx_res_t res_reg;
    ctx_t    ctx_reg;
    logic    vld_reg;

    assign res_next = fx_addsub(a, b, sub);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            ctx_reg <= ctx_in;
        end
    end

    assign vld_out = vld_reg;
    assign ctx_out = ctx_reg;
    assign y       = res_reg.v;
    assign ov      = res_reg.ov;

endmodule

@@ rtl/core/mge_mul.sv @@
module mge_mul
    import mge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic vld_in,
    input  ctx_t ctx_in,
    input  fx_t  a,
    input  fx_t  b,
    output logic vld_out,
    output ctx_t ctx_out,
    output fx_t  y,
    output logic ov
);

    logic [63:0] xa_reg;
    logic [63:0] ya_reg;
    logic        nega_reg;
    ctx_t        ctxa_reg;
    logic        vlda_reg;

    logic [63:0] p00_reg;
    logic [63:0] p01_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;
    logic        negb_reg;
    ctx_t        ctxb_reg;
    logic        vldb_reg;

    fx_res_t     res_reg;
    ctx_t        ctxc_reg;
    logic        vldc_reg;

    logic [63:0] mid;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [64:0] lo2;
    logic [63:0] hi2;
    fx_res_t     res_next;

    always_comb
    begin
        mid = {32'd0, p00_reg[63:32]} + {32'd0, p01_reg[31:0]} + {32'd0, p10_reg[31:0]};
        lo  = {mid[31:0], p00_reg[31:0]};
        hi  = p11_reg + {32'd0, p01_reg[63:32]} + {32'd0, p10_reg[63:32]}
              + {32'd0, mid[63:32]};
        lo2 = {1'b0, lo} + 65'h0_8000_0000;
        hi2 = hi + {63'd0, lo2[64]};
        res_next = fx_pack(negb_reg, {hi2[31:0], lo2[63:32]}, (hi2[63:32] != 32'd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlda_reg <= 1'b0;
            vldb_reg <= 1'b0;
            vldc_reg <= 1'b0;
        end
        else if (en)
        begin
            vlda_reg <= vld_in;
            vldb_reg <= vlda_reg;
            vldc_reg <= vldb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg   <= fx_mag(a);
            ya_reg   <= fx_mag(b);
            nega_reg <= a[63] ^ b[63];
            ctxa_reg <= ctx_in;
            p00_reg  <= 64'(xa_reg[31:0])  * 64'(ya_reg[31:0]);
            p01_reg  <= 64'(xa_reg[31:0])  * 64'(ya_reg[63:32]);
            p10_reg  <= 64'(xa_reg[63:32]) * 64'(ya_reg[31:0]);
            p11_reg  <= 64'(xa_reg[63:32]) * 64'(ya_reg[63:32]);
            negb_reg <= nega_reg;
            ctxb_reg <= ctxa_reg;
            res_reg  <= res_next;
            ctxc_reg <= ctxb_reg;
        end
    end

    assign vld_out = vldc_reg;
    assign ctx_out = ctxc_reg;
    assign y       = res_reg.v;
    assign ov      = res_reg.ov;

endmodule

@@ rtl/core/mge_div.sv @@
module mge_div
    import mge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic vld_in,
    input  ctx_t ctx_in,
    input  fx_t  a,
    input  fx_t  b,
    output logic vld_out,
    output ctx_t ctx_out,
    output fx_t  y,
    output logic ov
);

    logic [63:0]      r_reg   [0:QBITS];
    logic [QBITS-1:0] q_reg   [0:QBITS];
    logic [QBITS-1:0] n_reg   [0:QBITS];
    logic [63:0]      d_reg   [0:QBITS];
    logic             neg_reg [0:QBITS];
    ctx_t             ctx_reg [0:QBITS];
    logic             vld_reg [0:QBITS];

    logic [63:0]      r_next  [1:QBITS];
    logic [QBITS-1:0] q_next  [1:QBITS];
    logic [64:0]      rsh     [1:QBITS];
    logic             ge      [1:QBITS];

    fx_res_t          res_reg;
    ctx_t             ctxo_reg;
    logic             vldo_reg;

    logic             rnd;
    logic [QBITS:0]   qr;
    fx_res_t          res_next;

    always_comb
    begin
        for (int k = 1; k <= QBITS; k++)
        begin
            rsh[k]    = {r_reg[k-1], n_reg[k-1][QBITS-1]};
            ge[k]     = (rsh[k] >= {1'b0, d_reg[k-1]});
            r_next[k] = ge[k] ? 64'(rsh[k] - {1'b0, d_reg[k-1]}) : rsh[k][63:0];
            q_next[k] = {q_reg[k-1][QBITS-2:0], ge[k]};
        end
    end

    always_comb
    begin
        rnd      = ({r_reg[QBITS], 1'b0} >= {1'b0, d_reg[QBITS]});
        qr       = {1'b0, q_reg[QBITS]} + {{QBITS{1'b0}}, rnd};
        res_next = fx_pack(neg_reg[QBITS], qr[63:0], (qr[QBITS:64] != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QBITS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            vldo_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vld_in;
            for (int k = 1; k <= QBITS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            vldo_reg <= vld_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= 64'd0;
            q_reg[0]   <= '0;
            n_reg[0]   <= {fx_mag(a), 32'd0};
            d_reg[0]   <= fx_mag(b);
            neg_reg[0] <= a[63] ^ b[63];
            ctx_reg[0] <= ctx_in;
            for (int k = 1; k <= QBITS; k++)
            begin
                r_reg[k]   <= r_next[k];
                q_reg[k]   <= q_next[k];
                n_reg[k]   <= {n_reg[k-1][QBITS-2:0], 1'b0};
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ctx_reg[k] <= ctx_reg[k-1];
            end
            res_reg  <= res_next;
            ctxo_reg <= ctx_reg[QBITS];
        end
    end

    assign vld_out = vldo_reg;
    assign ctx_out = ctxo_reg;
    assign y       = res_reg.v;
    assign ov      = res_reg.ov;

endmodule

@@ rtl/core/mge_checker.sv @@
module mge_checker
    import mge_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input req_t        req,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input rsp_t        rsp,
    input logic        cfg_we,
    input cfg_idx_t    cfg_index,
    input logic [62:0] cfg_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("response changed while stalled");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall does not follow the response stall");

    a_bad_rho_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_BAD_RHO))
        |-> ((rsp.pressure == 64'sd0) && (rsp.bulk_modulus == 64'sd0)))
        else $error("nonzero result with bad density");

    a_bad_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_BAD_DEN))
        |-> ((rsp.pressure == 64'sd0) && (rsp.bulk_modulus == 64'sd0)))
        else $error("nonzero result with singular denominator");

endmodule

bind mie_gruneisen_eos_core mge_checker u_mge_checker (.*);

@@ tb/tb_mie_gruneisen_eos_core.sv @@
module tb_mie_gruneisen_eos_core;
    import mge_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 600;
    localparam logic [62:0] REG_ALL_ONES = {63{1'b1}};

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [62:0] cfg_data;

    logic [62:0] rho0_q;
    logic [62:0] gamma_q;
    logic [62:0] c0_q;
    logic [62:0] slope_q;

    req_t pending_q[$];
    rsp_t expected_q[$];
    int   fail_count;
    bit   quiet_mode;
    bit   long_hold;
    bit   hold_taken;
    int   hold_cnt;
    int   rx_wait;
    int   tx_gap;
    int   idle_cycles;

    mie_gruneisen_eos_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] abs_val(input fx_t x);
        return x[63] ? (64'd0 - 64'(x)) : 64'(x);
    endfunction

    function automatic fx_t clamp_signed(input bit neg, input logic [63:0] m, input bit big,
                                         inout bit ov);
        if (neg)
        begin
            if (big || m > 64'h8000_0000_0000_0000)
            begin
                ov = 1'b1;
                return FX_MIN;
            end
            return fx_t'(64'd0 - m);
        end
        if (big || m[63])
        begin
            ov = 1'b1;
            return FX_MAX;
        end
        return fx_t'(m);
    endfunction

    function automatic fx_t q_mul(input fx_t a, input fx_t b, inout bit ov);
        logic [127:0] pr;
        pr = 128'(abs_val(a)) * 128'(abs_val(b));
        pr = pr + 128'h8000_0000;
        return clamp_signed(a[63] ^ b[63], pr[95:32], pr[127:96] != 0, ov);
    endfunction

    function automatic fx_t q_div(input fx_t a, input fx_t b, inout bit ov);
        logic [127:0] num;
        logic [127:0] dv;
        logic [127:0] q;
        logic [127:0] rm;
        num = {32'd0, abs_val(a), 32'd0};
        dv  = 128'(abs_val(b));
        q   = num / dv;
        rm  = num % dv;
        if (rm >= dv - rm)
        begin
            q = q + 1;
        end
        return clamp_signed(a[63] ^ b[63], q[63:0], q[127:64] != 0, ov);
    endfunction

    function automatic fx_t q_add(input fx_t a, input fx_t b, inout bit ov);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            ov = 1'b1;
            return s[64] ? FX_MIN : FX_MAX;
        end
        return fx_t'(s[63:0]);
    endfunction

    function automatic fx_t q_sub(input fx_t a, input fx_t b, inout bit ov);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
        begin
            ov = 1'b1;
            return s[64] ? FX_MIN : FX_MAX;
        end
        return fx_t'(s[63:0]);
    endfunction

    function automatic rsp_t eos_response(input req_t item);
        rsp_t res;
        bit   ov;
        fx_t  rho, e, rho0, gam, c0, sl;
        fx_t  r, mu, den, us, u2, mm, rho0u2, ph, eh, g, p, dmu, dus, usdus, a, dph, deh;
        rho  = item.density;
        e    = item.internal_energy;
        rho0 = fx_t'({1'b0, rho0_q});
        gam  = fx_t'({1'b0, gamma_q});
        c0   = fx_t'({1'b0, c0_q});
        sl   = fx_t'({1'b0, slope_q});
        ov   = 1'b0;
        res.pressure     = '0;
        res.bulk_modulus = '0;
        if (rho <= 0)
        begin
            res.status = ST_BAD_RHO;
            return res;
        end
        r   = q_div(rho0, rho, ov);
        mu  = q_sub(FX_ONE, r, ov);
        den = q_sub(FX_ONE, q_mul(sl, (mu > 0) ? mu : fx_t'(0), ov), ov);
        if (den <= 0)
        begin
            res.status = ST_BAD_DEN;
            return res;
        end
        us     = q_div(c0, den, ov);
        u2     = q_mul(us, us, ov);
        mm     = q_mul(mu, mu, ov);
        rho0u2 = q_mul(rho0, u2, ov);
        ph     = q_mul(rho0u2, mu, ov);
        eh     = q_mul(FX_HALF, q_mul(u2, mm, ov), ov);
        g      = q_mul(gam, rho0, ov);
        p      = q_add(ph, q_mul(g, q_sub(e, eh, ov), ov), ov);
        dmu    = q_div(r, rho, ov);
        dus    = '0;
        if (mu > 0)
        begin
            dus = q_mul(q_div(q_mul(us, sl, ov), den, ov), dmu, ov);
        end
        usdus = q_mul(us, dus, ov);
        a     = q_mul(q_mul(rho0, usdus, ov), mu, ov);
        dph   = q_add(q_add(a, a, ov), q_mul(rho0u2, dmu, ov), ov);
        deh   = q_add(q_mul(usdus, mm, ov), q_mul(q_mul(u2, mu, ov), dmu, ov), ov);
        res.bulk_modulus = q_add(q_mul(rho, q_sub(dph, q_mul(g, deh, ov), ov), ov),
                                 q_mul(q_div(p, rho, ov), g, ov), ov);
        res.pressure = p;
        res.status   = ov ? ST_SAT : ST_OK;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            tx_gap    <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_q.push_back(eos_response(req));
            end
            if (!req_valid || !req_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap    <= tx_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    req       <= pending_q.pop_front();
                    req_valid <= 1'b1;
                    tx_gap    <= quiet_mode ? 0 : $urandom_range(0, 5);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            rx_wait    <= 0;
            hold_cnt   <= 0;
            hold_taken <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected response %p", $realtime, rsp);
                    fail_count++;
                end
                else
                begin
                    rsp_t exp_rsp;
                    exp_rsp = expected_q.pop_front();
                    if (rsp.pressure !== exp_rsp.pressure)
                    begin
                        $display("%0t: pressure expected %h actual %h", $realtime,
                                 exp_rsp.pressure, rsp.pressure);
                        fail_count++;
                    end
                    if (rsp.bulk_modulus !== exp_rsp.bulk_modulus)
                    begin
                        $display("%0t: bulk_modulus expected %h actual %h", $realtime,
                                 exp_rsp.bulk_modulus, rsp.bulk_modulus);
                        fail_count++;
                    end
                    if (rsp.status !== exp_rsp.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 exp_rsp.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (long_hold && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_cnt   <= HOLD_CYCLES;
                rsp_stall  <= 1'b1;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                rsp_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait   <= rx_wait - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (rsp_valid && !rsp_stall)
                begin
                    rx_wait <= quiet_mode ? 0 : $urandom_range(0, 5);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("mie_gruneisen_eos_core regression: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [62:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_RHO0:  rho0_q  <= value;
            REG_GAMMA: gamma_q <= value;
            REG_C0:    c0_q    <= value;
            default:   slope_q <= value;
        endcase
    endtask

    task automatic write_all(input logic [62:0] v0, input logic [62:0] v1,
                             input logic [62:0] v2, input logic [62:0] v3);
        write_reg(REG_RHO0, v0);
        write_reg(REG_GAMMA, v1);
        write_reg(REG_C0, v2);
        write_reg(REG_SLOPE, v3);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained;
        while (pending_q.size() > 0 || expected_q.size() > 0 || req_valid)
        begin
            @(posedge clk);
        end
    endtask

    function automatic req_t random_item;
        req_t it;
        if ($urandom_range(0, 4) == 0)
        begin
            it.density         = {$urandom, $urandom};
            it.internal_energy = {$urandom, $urandom};
        end
        else
        begin
            it.density = {30'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
            it.internal_energy = {{30{1'($urandom)}}, 2'($urandom), 32'($urandom)};
        end
        return it;
    endfunction

    function automatic logic [62:0] random_reg;
        return {29'd0, 2'($urandom_range(0, 3)), 31'($urandom), 1'b0};
    endfunction

    task automatic push_random(input int count);
        repeat (count) pending_q.push_back(random_item());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_RHO0;
        cfg_data   = '0;
        rho0_q     = 63'h1_0000_0000;
        gamma_q    = 63'h2_0000_0000;
        c0_q       = 63'h1_0000_0000;
        slope_q    = 63'h1_8000_0000;
        fail_count = 0;
        quiet_mode = 1'b0;
        long_hold  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        pending_q.push_back('{density: 64'sd0, internal_energy: 64'sd0});
        pending_q.push_back('{density: -FX_ONE, internal_energy: FX_ONE});
        pending_q.push_back('{density: FX_MIN, internal_energy: FX_MAX});
        pending_q.push_back('{density: FX_MAX, internal_energy: FX_MIN});
        pending_q.push_back('{density: FX_ONE, internal_energy: 64'sd0});
        pending_q.push_back('{density: FX_ONE, internal_energy: FX_ONE});
        pending_q.push_back('{density: 64'sh2_0000_0000, internal_energy: FX_HALF});
        pending_q.push_back('{density: 64'sh4_0000_0000, internal_energy: FX_ONE});
        pending_q.push_back('{density: 64'sh3_0000_0000, internal_energy: FX_ONE});
        pending_q.push_back('{density: FX_HALF, internal_energy: -FX_ONE});
        pending_q.push_back('{density: 64'sd1, internal_energy: FX_ONE});
        pending_q.push_back('{density: FX_ONE, internal_energy: FX_MAX});
        pending_q.push_back('{density: FX_ONE, internal_energy: FX_MIN});
        push_random(60);
        wait_drained();

        write_all(random_reg(), random_reg(), random_reg(), random_reg());
        long_hold <= 1'b1;
        push_random(240);
        wait_drained();

        write_all(63'd0, random_reg(), random_reg(), random_reg());
        quiet_mode <= 1'b1;
        push_random(70);
        wait_drained();
        quiet_mode <= 1'b0;

        write_all(63'd1, 63'd0, 63'd0, 63'd0);
        push_random(30);
        wait_drained();

        write_all(REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES);
        push_random(30);
        wait_drained();

        write_all(63'h1_0000_0000, 63'h2_0000_0000, 63'h1_0000_0000, REG_ALL_ONES);
        push_random(30);
        wait_drained();

        write_all(random_reg(), random_reg(), random_reg(), random_reg());
        push_random(30);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
        begin
            $display("mie_gruneisen_eos_core regression: pass");
        end
        else
        begin
            $display("mie_gruneisen_eos_core regression: fail");
        end
        $finish;
    end

endmodule
